### src/rcbg_pkg.sv
// Package for the radial cosine bit-plane generator.
// Holds the transfer types, register codes and the quarter-wave cosine
// function. Depends on nothing.
package rcbg_pkg;

  localparam int unsigned COORD_W    = 12;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned OUT_PLANES = 8;
  localparam int unsigned AMP_W      = 8;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IDX_W      = 4;   // pixel place within a word
  localparam int unsigned ENTRY_W    = 16;  // Q1.15 magnitude, 0..32768
  localparam int unsigned RAD_W      = 21;  // Q12.8 radius with headroom

  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 1'b1;

  localparam logic [AMP_W-1:0]  AMP_RESET  = 8'd31;
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd1394;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [10] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
    64'd132, 64'd182, 64'd240, 64'd306, 64'd380
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] group_x;
    logic signed [COORD_W-1:0] row_y;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] plane_0;
    logic [WORD_W-1:0] plane_1;
    logic [WORD_W-1:0] plane_2;
    logic [WORD_W-1:0] plane_3;
    logic [WORD_W-1:0] plane_4;
    logic [WORD_W-1:0] plane_5;
    logic [WORD_W-1:0] plane_6;
    logic [WORD_W-1:0] plane_7;
  } out_item_t;

  // Travels with every pixel down the pipe
  typedef struct packed {
    logic             last;
    logic [IDX_W-1:0] idx;
  } pix_tag_t;

  // cos(pi/2 * k / 2^(bits-2)) in Q15, Taylor series in Q30.
  // Only evaluated at elaboration to build the constant table.
  function automatic logic [ENTRY_W-1:0] cos_quadrant_q15(input int unsigned k,
                                                          input int unsigned bits);
    logic [63:0]        t;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    t    = (HALF_PI_Q30 * 64'(k)) >> (bits - 2);
    t2   = (t * t) >> 30;
    term = 64'd1 << 30;
    sum  = signed'(term);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * t2) >> 30) / TAYLOR_DIV[n-1];
      if ((n & 1) == 1) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    if (sum < 0) sum = 64'sd0;
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32768) sum = 64'sd32768;
    return sum[ENTRY_W-1:0];
  endfunction

endpackage

### src/rcbg_radius.sv
// Radius stages: absolute coordinates, squares, sum, then a pipelined
// restoring square root giving the Q12.8 radius. Uses rcbg_pkg.
module rcbg_radius (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  rcbg_pkg::pix_tag_t               tag_i,
  input  logic signed [rcbg_pkg::COORD_W:0] x_i,
  input  logic signed [rcbg_pkg::COORD_W-1:0] y_i,
  output logic                             valid_o,
  output rcbg_pkg::pix_tag_t               tag_o,
  output logic [rcbg_pkg::RAD_W-1:0]       radius_o
);

  localparam int unsigned CW     = rcbg_pkg::COORD_W;
  localparam int unsigned SQ_W   = 2 * CW;
  localparam int unsigned V_W    = 41;          // (sum of squares) << 16
  localparam int unsigned ITERS  = 21;          // one per result bit
  localparam int unsigned PER_ST = 3;
  localparam int unsigned STAGES = ITERS / PER_ST;

  // Stage A: magnitudes
  logic               a_valid_q;
  rcbg_pkg::pix_tag_t a_tag_q;
  logic [CW-1:0]      ax_q, ay_q;
  logic signed [CW:0] y_ext;
  logic signed [CW:0] ax_full, ay_full;

  always_comb begin
    y_ext   = {y_i[CW-1], y_i};
    ax_full = (x_i < 0) ? -x_i : x_i;
    ay_full = (y_ext < 0) ? -y_ext : y_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_tag_q <= tag_i;
      ax_q    <= ax_full[CW-1:0];
      ay_q    <= ay_full[CW-1:0];
    end
  end

  // Stage B: squares
  logic               b_valid_q;
  rcbg_pkg::pix_tag_t b_tag_q;
  logic [SQ_W-1:0]    sx_q, sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_tag_q <= a_tag_q;
      sx_q    <= ax_q * ax_q;
      sy_q    <= ay_q * ay_q;
    end
  end

  // Stage C: sum, scaled to Q.16 before the root
  logic               c_valid_q;
  rcbg_pkg::pix_tag_t c_tag_q;
  logic [V_W-1:0]     c_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_tag_q <= b_tag_q;
      c_v_q   <= V_W'({1'b0, sx_q} + {1'b0, sy_q}) << 16;
    end
  end

  // Root stages, a few iterations each
  logic               r_valid_q [STAGES];
  rcbg_pkg::pix_tag_t r_tag_q   [STAGES];
  logic [V_W-1:0]     r_rem_q   [STAGES];
  logic [V_W-1:0]     r_res_q   [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_root
    logic               in_valid;
    rcbg_pkg::pix_tag_t in_tag;
    logic [V_W-1:0]     in_rem, in_res;
    logic [V_W-1:0]     rem_d, res_d;

    if (s == 0) begin : g_first
      assign in_valid = c_valid_q;
      assign in_tag   = c_tag_q;
      assign in_rem   = c_v_q;
      assign in_res   = '0;
    end else begin : g_next
      assign in_valid = r_valid_q[s-1];
      assign in_tag   = r_tag_q[s-1];
      assign in_rem   = r_rem_q[s-1];
      assign in_res   = r_res_q[s-1];
    end

    always_comb begin
      logic [V_W-1:0] bit_v;
      logic [V_W-1:0] trial;
      rem_d = in_rem;
      res_d = in_res;
      for (int t = 0; t < PER_ST; t++) begin
        bit_v = V_W'(1) << (V_W - 1 - 2 * (s * PER_ST + t));
        trial = res_d + bit_v;
        if (rem_d >= trial) begin
          rem_d = rem_d - trial;
          res_d = (res_d >> 1) + bit_v;
        end else begin
          res_d = res_d >> 1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        r_valid_q[s] <= 1'b0;
      end else if (en_i) begin
        r_valid_q[s] <= in_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_tag_q[s] <= in_tag;
        r_rem_q[s] <= rem_d;
        r_res_q[s] <= res_d;
      end
    end
  end

  assign valid_o  = r_valid_q[STAGES-1];
  assign tag_o    = r_tag_q[STAGES-1];
  assign radius_o = r_res_q[STAGES-1][rcbg_pkg::RAD_W-1:0];

endmodule

### src/rcbg_shade.sv
// Shading stages: phase from radius, quarter-wave cosine lookup and
// amplitude scaling to an 8-bit magnitude. Uses rcbg_pkg.
module rcbg_shade #(
  parameter int unsigned COS_TABLE_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [rcbg_pkg::AMP_W-1:0]    amplitude_i,
  input  logic [rcbg_pkg::STEP_W-1:0]   phase_step_i,
  input  logic                          valid_i,
  input  rcbg_pkg::pix_tag_t            tag_i,
  input  logic [rcbg_pkg::RAD_W-1:0]    radius_i,
  output logic                          valid_o,
  output rcbg_pkg::pix_tag_t            tag_o,
  output logic [rcbg_pkg::AMP_W-1:0]    mag_o
);

  localparam int unsigned B   = COS_TABLE_BITS;
  localparam int unsigned N   = 1 << B;
  localparam int unsigned Q   = N >> 2;
  localparam int unsigned KW  = B - 1;
  localparam int unsigned EW  = rcbg_pkg::ENTRY_W;
  localparam int unsigned PW  = rcbg_pkg::RAD_W + rcbg_pkg::STEP_W;

  // Constant quarter-wave table, entries 0..Q
  logic [EW-1:0] cos_tab [Q+1];
  for (genvar g = 0; g <= Q; g++) begin : g_tab
    localparam logic [EW-1:0] Entry = rcbg_pkg::cos_quadrant_q15(g, B);
    assign cos_tab[g] = Entry;
  end

  // Stage 1: phase fraction, top bits form the table index
  logic               p_valid_q;
  rcbg_pkg::pix_tag_t p_tag_q;
  logic [B-1:0]       p_idx_q;
  logic [PW-1:0]      prod;

  assign prod = radius_i * phase_step_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (en_i) begin
      p_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_tag_q <= tag_i;
      p_idx_q <= prod[23:24-B];
    end
  end

  // Stage 2: fold into the first quadrant and look up
  logic               l_valid_q;
  rcbg_pkg::pix_tag_t l_tag_q;
  logic [EW-1:0]      l_entry_q;
  logic [B:0]         idx_w, k_w;

  always_comb begin
    idx_w = {1'b0, p_idx_q};
    if (idx_w <= (B+1)'(Q))          k_w = idx_w;
    else if (idx_w <= (B+1)'(2 * Q)) k_w = (B+1)'(2 * Q) - idx_w;
    else if (idx_w <= (B+1)'(3 * Q)) k_w = idx_w - (B+1)'(2 * Q);
    else                             k_w = (B+1)'(N) - idx_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_valid_q <= 1'b0;
    end else if (en_i) begin
      l_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_tag_q   <= p_tag_q;
      l_entry_q <= cos_tab[k_w[KW-1:0]];
    end
  end

  // Stage 3: scale, truncation toward zero of the magnitude
  logic               m_valid_q;
  rcbg_pkg::pix_tag_t m_tag_q;
  logic [rcbg_pkg::AMP_W-1:0]    m_mag_q;
  logic [rcbg_pkg::AMP_W+EW-1:0] scaled;

  assign scaled = amplitude_i * l_entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en_i) begin
      m_valid_q <= l_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_tag_q <= l_tag_q;
      m_mag_q <= scaled[15 +: rcbg_pkg::AMP_W];
    end
  end

  assign valid_o = m_valid_q;
  assign tag_o   = m_tag_q;
  assign mag_o   = m_mag_q;

endmodule

### src/rcbg_pack.sv
// Plane packer: spreads pixel magnitude bits over the plane words and
// holds the finished group in the output register. Uses rcbg_pkg.
module rcbg_pack #(
  parameter int unsigned PLANE_COUNT = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  rcbg_pkg::pix_tag_t         tag_i,
  input  logic [rcbg_pkg::AMP_W-1:0] mag_i,
  output logic                       en_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rcbg_pkg::out_item_t        out_data_o
);

  localparam int unsigned WW = rcbg_pkg::WORD_W;
  localparam int unsigned OP = rcbg_pkg::OUT_PLANES;

  logic [WW-1:0] acc_q [PLANE_COUNT];
  logic [WW-1:0] cur   [PLANE_COUNT];
  logic [WW-1:0] res_q [PLANE_COUNT];
  logic [WW-1:0] word  [OP];
  logic [WW-1:0] pos;
  logic          out_valid_q, out_valid_d;

  // Pipe holds only when a finished group meets a result still waiting
  assign en_o = !(out_valid_q && !out_ready_i && valid_i && tag_i.last);
  assign pos  = WW'(16'h8000) >> tag_i.idx;

  // Merge this pixel; the first pixel of a group starts clean
  always_comb begin
    for (int p = 0; p < PLANE_COUNT; p++) begin
      cur[p] = (tag_i.idx == '0) ? '0 : acc_q[p];
      if (mag_i[p]) cur[p] = cur[p] | pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && valid_i) begin
      for (int p = 0; p < PLANE_COUNT; p++) acc_q[p] <= cur[p];
      if (tag_i.last) begin
        for (int p = 0; p < PLANE_COUNT; p++) res_q[p] <= cur[p];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (en_o && valid_i && tag_i.last) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Planes past PLANE_COUNT read as zero
  always_comb begin
    for (int p = 0; p < OP; p++) word[p] = '0;
    for (int p = 0; p < PLANE_COUNT; p++) word[p] = res_q[p];
  end

  assign out_valid_o        = out_valid_q;
  assign out_data_o.plane_0 = word[0];
  assign out_data_o.plane_1 = word[1];
  assign out_data_o.plane_2 = word[2];
  assign out_data_o.plane_3 = word[3];
  assign out_data_o.plane_4 = word[4];
  assign out_data_o.plane_5 = word[5];
  assign out_data_o.plane_6 = word[6];
  assign out_data_o.plane_7 = word[7];

endmodule

### src/radial_cosine_bitplane_generator.sv
// Top level of the radial cosine bit-plane generator.
// Instantiates rcbg_radius, rcbg_shade and rcbg_pack; uses rcbg_pkg.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o/in_data_i): one transfer gives the
//    leftmost pixel x of a group and the row y.
//  - Output channel (out_valid_o/out_ready_i/out_data_o): one transfer per
//    input, eight 16-bit plane words, pixel 0 at bit 15.
//  - Config port (cfg_we_i/cfg_idx_i/cfg_data_i): index 0 amplitude,
//    index 1 phase_step; write only while the block is idle.
// Throughput: pixels go down a single pixel pipe one per cycle while the
// pipe is not stalled; groups follow without gaps. A new group is taken
// while the previous one is still being issued.
// Path to out_valid_o: issue from the holding register, 3 radius stages
// (magnitudes, squares, sum), 7 root stages, 3 shading stages, packer.
// Reset: pipe empty, amplitude 31, phase_step 1394.
// Stall: the whole pixel pipe freezes only when the last pixel of a group
// reaches the packer while the previous result still waits on out_ready_i;
// nothing is lost and the input is held off once its holding register fills.
module radial_cosine_bitplane_generator #(
  parameter int unsigned PIXELS_PER_GROUP = 16,
  parameter int unsigned PLANE_COUNT      = 8,
  parameter int unsigned COS_TABLE_BITS   = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rcbg_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rcbg_pkg::out_item_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [rcbg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rcbg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned NPIX  = (PIXELS_PER_GROUP < 16) ? PIXELS_PER_GROUP : 16;
  localparam int unsigned CNT_W = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NPIX - 1);
  localparam int unsigned CW    = rcbg_pkg::COORD_W;

  // Configuration registers
  logic [rcbg_pkg::AMP_W-1:0]  amp_q;
  logic [rcbg_pkg::STEP_W-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q  <= rcbg_pkg::AMP_RESET;
      step_q <= rcbg_pkg::STEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rcbg_pkg::CFG_AMPLITUDE:  amp_q  <= cfg_data_i[rcbg_pkg::AMP_W-1:0];
        rcbg_pkg::CFG_PHASE_STEP: step_q <= cfg_data_i[rcbg_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Group holding register and pixel issue counter
  logic               en;
  logic               hold_valid_q, hold_valid_d;
  rcbg_pkg::in_item_t hold_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               issue, issue_last, in_xfer;

  assign issue      = hold_valid_q && en;
  assign issue_last = issue && (cnt_q == LAST);
  assign in_ready_o = !hold_valid_q || issue_last;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    hold_valid_d = hold_valid_q;
    cnt_d        = cnt_q;
    if (issue) cnt_d = issue_last ? '0 : cnt_q + 1'b1;
    if (issue_last) hold_valid_d = 1'b0;
    if (in_xfer) hold_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      cnt_q        <= '0;
    end else begin
      hold_valid_q <= hold_valid_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) hold_q <= in_data_i;
  end

  // Pixel coordinate, formed without wrap
  logic signed [CW:0]  pix_x;
  rcbg_pkg::pix_tag_t  pix_tag;

  assign pix_x        = {hold_q.group_x[CW-1], hold_q.group_x} + signed'({1'b0, (CW)'(cnt_q)});
  assign pix_tag.idx  = rcbg_pkg::IDX_W'(cnt_q);
  assign pix_tag.last = (cnt_q == LAST);

  logic                          rad_valid;
  rcbg_pkg::pix_tag_t            rad_tag;
  logic [rcbg_pkg::RAD_W-1:0]    rad;
  logic                          sh_valid;
  rcbg_pkg::pix_tag_t            sh_tag;
  logic [rcbg_pkg::AMP_W-1:0]    sh_mag;

  rcbg_radius u_radius (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (hold_valid_q),
    .tag_i    (pix_tag),
    .x_i      (pix_x),
    .y_i      (hold_q.row_y),
    .valid_o  (rad_valid),
    .tag_o    (rad_tag),
    .radius_o (rad)
  );

  rcbg_shade #(
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_shade (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .amplitude_i  (amp_q),
    .phase_step_i (step_q),
    .valid_i      (rad_valid),
    .tag_i        (rad_tag),
    .radius_i     (rad),
    .valid_o      (sh_valid),
    .tag_o        (sh_tag),
    .mag_o        (sh_mag)
  );

  rcbg_pack #(
    .PLANE_COUNT (PLANE_COUNT)
  ) u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (sh_valid),
    .tag_i       (sh_tag),
    .mag_i       (sh_mag),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LAST) else $error("pixel counter past group end");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hold_valid_q |-> cnt_q == '0) else $error("counter moved without a group");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(cnt_q)) else $error("issue advanced during stall");

endmodule

### tb/tb.sv
// Testbench for the radial cosine bit-plane generator.
// Drives group coordinates and register writes, predicts the plane words
// from its own cosine table and radius arithmetic. Depends on rcbg_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_PIX    = 16;
  localparam int unsigned N_PLANES = 8;
  localparam int unsigned TAB_BITS = 10;
  localparam int          TAB_Q    = (1 << TAB_BITS) / 4;
  localparam int unsigned LATENCY  = N_PIX + 13;
  localparam longint      CYCLE_LIMIT = 400000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  rcbg_pkg::in_item_t    in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  rcbg_pkg::out_item_t   out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [rcbg_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [rcbg_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  radial_cosine_bitplane_generator dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [rcbg_pkg::AMP_W-1:0]  amp_q;
  logic [rcbg_pkg::STEP_W-1:0] step_q;
  int                cos_tab [1 << TAB_BITS];
  rcbg_pkg::out_item_t planes_q [$];
  int                n_err = 0;
  int                n_seen = 0;
  int                send_idle = 0;
  int                recv_idle = 0;
  longint            cyc = 0;
  int                amps [4] = '{0, 255, 1, 200};
  int                steps [4] = '{65535, 0, 1, 40000};

  // Directed table: coordinates, with a slot for expected words that no row here uses
  typedef struct {
    int                  gx;
    int                  gy;
    bit                  known;
    rcbg_pkg::out_item_t want;
  } row_t;
  row_t dir_rows [$];

  function automatic int cos_q15_quarter(int k, int q);
    longint unsigned t, t2, term;
    longint s;
    if (q == 0) return 32768;
    t = (64'd1686629713 * longint'(k)) / q;
    t2 = (t * t) >> 30;
    term = 64'd1 << 30;
    s = 1 << 30;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * t2) >> 30) / longint'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) s -= longint'(term);
      else s += longint'(term);
    end
    if (s < 0) s = 0;
    s = (s + (1 << 14)) >>> 15;
    if (s > 32768) s = 32768;
    return int'(s);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic rcbg_pkg::out_item_t shade_group(int gx, int gy);
    logic [rcbg_pkg::WORD_W-1:0] pw [N_PLANES];
    longint            x, ax, ay, r2, v;
    longint unsigned   rad, frac, mag;
    int                idx;
    rcbg_pkg::out_item_t o;
    foreach (pw[p]) pw[p] = '0;
    for (int i = 0; i < N_PIX; i++) begin
      x = gx + i;
      ax = x < 0 ? -x : x;
      ay = gy < 0 ? -gy : gy;
      r2 = ax * ax + ay * ay;
      rad = int_sqrt(r2 << 16);
      frac = (rad * longint'(step_q)) & 64'hFFFFFF;
      idx = int'(frac >> (24 - TAB_BITS));
      v = longint'(amp_q) * cos_tab[idx];
      mag = (v < 0 ? -v : v) >> 15;
      for (int p = 0; p < N_PLANES; p++) pw[p][15 - i] = mag[p];
    end
    o = '{pw[0], pw[1], pw[2], pw[3], pw[4], pw[5], pw[6], pw[7]};
    return o;
  endfunction

  task automatic report(input string what);
    n_err++;
    $display("MISMATCH %s at cycle %0d", what, cyc);
  endtask

  // Output side: stall at random, check every transfer
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_seen++;
      if (planes_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        rcbg_pkg::out_item_t w;
        w = planes_q.pop_front();
        if (out_data_o.plane_0 !== w.plane_0) report("plane_0");
        if (out_data_o.plane_1 !== w.plane_1) report("plane_1");
        if (out_data_o.plane_2 !== w.plane_2) report("plane_2");
        if (out_data_o.plane_3 !== w.plane_3) report("plane_3");
        if (out_data_o.plane_4 !== w.plane_4) report("plane_4");
        if (out_data_o.plane_5 !== w.plane_5) report("plane_5");
        if (out_data_o.plane_6 !== w.plane_6) report("plane_6");
        if (out_data_o.plane_7 !== w.plane_7) report("plane_7");
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  task automatic write_reg(input logic [rcbg_pkg::CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[rcbg_pkg::CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rcbg_pkg::CFG_AMPLITUDE) amp_q = val[rcbg_pkg::AMP_W-1:0];
    else step_q = val[rcbg_pkg::STEP_W-1:0];
  endtask

  // One input transfer; the expectation is queued when accepted.
  // Valid stays up after the transfer until the next call or a drain.
  task automatic send_group(input int gx, input int gy, input bit known,
                            input rcbg_pkg::out_item_t want);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i.group_x <= gx[rcbg_pkg::COORD_W-1:0];
    in_data_i.row_y <= gy[rcbg_pkg::COORD_W-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    planes_q.push_back(known ? want : shade_group(gx, gy));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (planes_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(3))
      0: return $urandom_range(4095) - 2048;
      1: return $urandom_range(80) - 40;
      2: return $urandom_range(1) ? 2047 - $urandom_range(20) : -2048 + $urandom_range(20);
      default: return $urandom_range(600) - 300;
    endcase
  endfunction

  initial begin
    rcbg_pkg::out_item_t zero_w, full_w;
    zero_w = '0;
    full_w = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
               16'h0000, 16'h0000, 16'h0000};
    // Quarter-wave table mirrored into the full turn
    for (int k = 0; k < (1 << TAB_BITS); k++) begin
      if (k <= TAB_Q) cos_tab[k] = cos_q15_quarter(k, TAB_Q);
      else if (k <= 2 * TAB_Q) cos_tab[k] = -cos_q15_quarter(2 * TAB_Q - k, TAB_Q);
      else if (k <= 3 * TAB_Q) cos_tab[k] = -cos_q15_quarter(k - 2 * TAB_Q, TAB_Q);
      else cos_tab[k] = cos_q15_quarter(4 * TAB_Q - k, TAB_Q);
    end
    amp_q = rcbg_pkg::AMP_RESET;
    step_q = rcbg_pkg::STEP_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows at the origin, the corners and edges of the coordinate range, and two mid-range rows
    dir_rows.push_back('{0, 0, 0, zero_w});
    dir_rows.push_back('{2047, 2047, 0, zero_w});
    dir_rows.push_back('{-2048, -2048, 0, zero_w});
    dir_rows.push_back('{2040, 0, 0, zero_w});
    dir_rows.push_back('{-8, -2048, 0, zero_w});
    dir_rows.push_back('{-2048, 2047, 0, zero_w});
    dir_rows.push_back('{2047, -2048, 0, zero_w});
    dir_rows.push_back('{-1366, 1365, 0, zero_w});
    dir_rows.push_back('{1365, -1366, 0, zero_w});
    send_idle = 28;
    recv_idle = 56;
    foreach (dir_rows[r]) send_group(dir_rows[r].gx, dir_rows[r].gy, 0, zero_w);
    drain();
    // Zero step gives the full amplitude 31 on every pixel
    write_reg(rcbg_pkg::CFG_PHASE_STEP, 0);
    send_group(-2048, -2048, 1, full_w);
    send_group(2047, 2047, 1, full_w);
    drain();
    write_reg(rcbg_pkg::CFG_AMPLITUDE, 0);
    send_group(100, -5, 1, zero_w);
    send_group(-2048, 2047, 1, zero_w);
    drain();
    write_reg(rcbg_pkg::CFG_AMPLITUDE, 255);
    write_reg(rcbg_pkg::CFG_PHASE_STEP, 65535);
    foreach (dir_rows[r]) send_group(dir_rows[r].gx, dir_rows[r].gy, 0, zero_w);
    drain();

    // Random phases, each with its own sender and receiver balance and four register settings
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 28 : (ph == 1 ? 56 : 0);
      recv_idle = ph == 0 ? 56 : (ph == 1 ? 28 : 0);
      for (int s = 0; s < 4; s++) begin
        write_reg(rcbg_pkg::CFG_AMPLITUDE,
                  s == 0 ? amps[(ph + s) % 4] : $urandom_range(255));
        write_reg(rcbg_pkg::CFG_PHASE_STEP,
                  s == 1 ? steps[(ph + s) % 4] : $urandom_range(65535));
        for (int n = 0; n < 75; n++) send_group(rand_coord(), rand_coord(), 0, zero_w);
        drain();
      end
    end

    $display("covered %0d groups over several amplitude and phase step settings,", n_seen);
    $display("with random sender gaps and receiver stalls in both balances");
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

### files.f
src/rcbg_pkg.sv
src/rcbg_radius.sv
src/rcbg_shade.sv
src/rcbg_pack.sv
src/radial_cosine_bitplane_generator.sv
tb/tb.sv
